// ===== rtl/tlvx_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvx_pkg: shared types and constants
// Result word layout, register map, parse phases and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvx_pkg;

  // Configuration register map
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAGIC      = 3'd0,
    REG_MICR_TYPE  = 3'd1,
    REG_PAYEE_TYPE = 3'd2,
    REG_MEMO_TYPE  = 3'd3,
    REG_MICR_LIM   = 3'd4,
    REG_PAYEE_LIM  = 3'd5,
    REG_MEMO_LIM   = 3'd6
  } cfg_reg_e;

  localparam logic [31:0] MagicReset     = 32'h3151_4843;
  localparam logic [7:0]  MicrTypeReset  = 8'd1;
  localparam logic [7:0]  PayeeTypeReset = 8'd2;
  localparam logic [7:0]  MemoTypeReset  = 8'd3;
  localparam logic [7:0]  LimitReset     = 8'd63;

  // Default clip on kept field length and result queue depth
  localparam int unsigned MaxFieldBytesDef = 255;
  localparam int unsigned ResultDepthDef   = 4;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  micr_type_code;
    logic [7:0]  payee_type_code;
    logic [7:0]  memo_type_code;
    logic [7:0]  micr_limit;
    logic [7:0]  payee_limit;
    logic [7:0]  memo_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    FIELD_MICR  = 2'd0,
    FIELD_PAYEE = 2'd1,
    FIELD_MEMO  = 2'd2,
    FIELD_NONE  = 2'd3
  } field_e;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_COUNT   = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAIL   = 3'd4,
    PH_BAD     = 3'd5
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    field_e      field_id;
    logic [7:0]  kept_length;
    logic [7:0]  byte_index;
    logic [7:0]  byte_value;
    logic        status;
    logic [31:0] rec_total;
    logic        run_last;
  } result_t;

  // Up to two result words pushed per input byte
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/tlvx_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tlvx_cfg_regs: configuration register file
// Seven registers written through a valid/ready port; unknown indexes ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvx_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tlvx_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [tlvx_pkg::CfgDataW-1:0]  cfg_data_i,
  output tlvx_pkg::cfg_t                      cfg_o
);

  tlvx_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tlvx_pkg::REG_MAGIC:      cfg_d.magic_word      = cfg_data_i[31:0];
        tlvx_pkg::REG_MICR_TYPE:  cfg_d.micr_type_code  = cfg_data_i[7:0];
        tlvx_pkg::REG_PAYEE_TYPE: cfg_d.payee_type_code = cfg_data_i[7:0];
        tlvx_pkg::REG_MEMO_TYPE:  cfg_d.memo_type_code  = cfg_data_i[7:0];
        tlvx_pkg::REG_MICR_LIM:   cfg_d.micr_limit      = cfg_data_i[7:0];
        tlvx_pkg::REG_PAYEE_LIM:  cfg_d.payee_limit     = cfg_data_i[7:0];
        tlvx_pkg::REG_MEMO_LIM:   cfg_d.memo_limit      = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word      <= tlvx_pkg::MagicReset;
      cfg_q.micr_type_code  <= tlvx_pkg::MicrTypeReset;
      cfg_q.payee_type_code <= tlvx_pkg::PayeeTypeReset;
      cfg_q.memo_type_code  <= tlvx_pkg::MemoTypeReset;
      cfg_q.micr_limit      <= tlvx_pkg::LimitReset;
      cfg_q.payee_limit     <= tlvx_pkg::LimitReset;
      cfg_q.memo_limit      <= tlvx_pkg::LimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/tlvx_parser.sv =====
// ----------------------------------------------------------------------------
// tlvx_parser: byte-wide container parser
// One byte per accept: updates header/payload state, builds up to two words.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvx_parser #(
  parameter int unsigned MaxFieldBytes = tlvx_pkg::MaxFieldBytesDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           final_byte_i,
  input  wire tlvx_pkg::cfg_t cfg_i,
  output tlvx_pkg::push_t     push_o
);

  localparam logic [7:0] MaxKeep = 8'(MaxFieldBytes);

  tlvx_pkg::phase_e phase_q, phase_d;
  tlvx_pkg::field_e active_q, active_d;
  logic [2:0]  hdr_pos_q, hdr_pos_d;
  logic [31:0] rec_left_q, rec_left_d;
  logic [31:0] rec_seen_q, rec_seen_d;
  logic [7:0]  rec_type_q, rec_type_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic [31:0] pay_left_q, pay_left_d;
  logic [7:0]  pay_pos_q, pay_pos_d;
  logic [7:0]  keep_q, keep_d;

  logic [1:0]  pos_m;
  logic [2:0]  pos_h;
  logic [1:0]  lane_h;
  logic [7:0]  lim;
  logic        end_rec;
  logic        fld_vld;
  logic        bad;
  tlvx_pkg::result_t fld_res, done_res;
  tlvx_pkg::push_t   push;

  always_comb begin
    phase_d    = phase_q;
    active_d   = active_q;
    hdr_pos_d  = hdr_pos_q;
    rec_left_d = rec_left_q;
    rec_seen_d = rec_seen_q;
    rec_type_d = rec_type_q;
    len_acc_d  = len_acc_q;
    pay_left_d = pay_left_q;
    pay_pos_d  = pay_pos_q;
    keep_d     = keep_q;
    end_rec    = 1'b0;
    fld_vld    = 1'b0;
    fld_res    = '0;
    lim        = '0;
    bad        = 1'b0;
    done_res   = '0;
    push       = '0;

    pos_m  = (hdr_pos_q > 3'd3) ? 2'd3 : hdr_pos_q[1:0];
    pos_h  = (hdr_pos_q > 3'd4) ? 3'd4 : hdr_pos_q;
    lane_h = 2'(pos_h - 3'd1);

    unique case (phase_q)
      tlvx_pkg::PH_MAGIC: begin
        if (((cfg_i.magic_word >> {pos_m, 3'b000}) & 32'hFF) != 32'(data_byte_i)) begin
          phase_d = tlvx_pkg::PH_BAD;
        end else if (pos_m == 2'd3) begin
          phase_d   = tlvx_pkg::PH_COUNT;
          hdr_pos_d = '0;
          len_acc_d = '0;
        end else begin
          hdr_pos_d = 3'(pos_m) + 3'd1;
        end
      end
      tlvx_pkg::PH_COUNT: begin
        len_acc_d = len_acc_q | (32'(data_byte_i) << {pos_m, 3'b000});
        if (pos_m == 2'd3) begin
          rec_left_d = len_acc_d;
          rec_seen_d = '0;
          end_rec    = 1'b1;
        end else begin
          hdr_pos_d = 3'(pos_m) + 3'd1;
        end
      end
      tlvx_pkg::PH_HEADER: begin
        if (hdr_pos_q == 3'd0) begin
          rec_type_d = data_byte_i;
          len_acc_d  = '0;
          hdr_pos_d  = 3'd1;
        end else begin
          len_acc_d = len_acc_q | (32'(data_byte_i) << {lane_h, 3'b000});
          if (pos_h < 3'd4) begin
            hdr_pos_d = pos_h + 3'd1;
          end else begin
            rec_left_d = rec_left_q - 32'd1;
            rec_seen_d = rec_seen_q + 32'd1;
            pay_left_d = len_acc_d;
            pay_pos_d  = '0;
            // lower field wins where type codes are shared
            if (rec_type_q == cfg_i.micr_type_code) begin
              active_d = tlvx_pkg::FIELD_MICR;
              lim      = cfg_i.micr_limit;
            end else if (rec_type_q == cfg_i.payee_type_code) begin
              active_d = tlvx_pkg::FIELD_PAYEE;
              lim      = cfg_i.payee_limit;
            end else if (rec_type_q == cfg_i.memo_type_code) begin
              active_d = tlvx_pkg::FIELD_MEMO;
              lim      = cfg_i.memo_limit;
            end else begin
              active_d = tlvx_pkg::FIELD_NONE;
            end
            if (lim > MaxKeep) lim = MaxKeep;
            keep_d = (len_acc_d < 32'(lim)) ? len_acc_d[7:0] : lim;
            if (active_d != tlvx_pkg::FIELD_NONE) begin
              fld_vld             = 1'b1;
              fld_res.kind        = tlvx_pkg::KIND_BEGIN;
              fld_res.field_id    = active_d;
              fld_res.kept_length = keep_d;
            end
            if (len_acc_d == '0) begin
              end_rec = 1'b1;
            end else begin
              phase_d   = tlvx_pkg::PH_PAYLOAD;
              hdr_pos_d = '0;
            end
          end
        end
      end
      tlvx_pkg::PH_PAYLOAD: begin
        if (active_q != tlvx_pkg::FIELD_NONE && pay_pos_q < keep_q) begin
          fld_vld            = 1'b1;
          fld_res.kind       = tlvx_pkg::KIND_BYTE;
          fld_res.field_id   = active_q;
          fld_res.byte_index = pay_pos_q;
          fld_res.byte_value = data_byte_i;
          pay_pos_d          = pay_pos_q + 8'd1;
        end
        pay_left_d = pay_left_q - 32'd1;
        if (pay_left_d == '0) end_rec = 1'b1;
      end
      default: ;
    endcase

    // record closed: back to header or to trailing bytes
    if (end_rec) begin
      active_d  = tlvx_pkg::FIELD_NONE;
      pay_pos_d = '0;
      keep_d    = '0;
      hdr_pos_d = '0;
      len_acc_d = '0;
      phase_d   = (rec_left_d != '0) ? tlvx_pkg::PH_HEADER : tlvx_pkg::PH_TRAIL;
    end

    if (final_byte_i) begin
      bad = (phase_d == tlvx_pkg::PH_MAGIC) || (phase_d == tlvx_pkg::PH_COUNT) ||
            (phase_d == tlvx_pkg::PH_BAD);
      done_res.kind      = tlvx_pkg::KIND_DONE;
      done_res.field_id  = tlvx_pkg::FIELD_MICR;
      done_res.status    = bad;
      done_res.rec_total = bad ? '0 : rec_seen_d;
      done_res.run_last  = 1'b1;
      phase_d    = tlvx_pkg::PH_MAGIC;
      hdr_pos_d  = '0;
      rec_left_d = '0;
      rec_seen_d = '0;
      rec_type_d = '0;
      len_acc_d  = '0;
      pay_left_d = '0;
      pay_pos_d  = '0;
      active_d   = tlvx_pkg::FIELD_NONE;
      keep_d     = '0;
    end

    if (accept_i) begin
      if (fld_vld) begin
        push.r0          = fld_res;
        push.r0.run_last = !final_byte_i;
        push.r1          = done_res;
        push.n           = final_byte_i ? 2'd2 : 2'd1;
      end else if (final_byte_i) begin
        push.r0 = done_res;
        push.n  = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tlvx_pkg::PH_MAGIC;
      active_q   <= tlvx_pkg::FIELD_NONE;
      hdr_pos_q  <= '0;
      rec_left_q <= '0;
      rec_seen_q <= '0;
      rec_type_q <= '0;
      len_acc_q  <= '0;
      pay_left_q <= '0;
      pay_pos_q  <= '0;
      keep_q     <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      active_q   <= active_d;
      hdr_pos_q  <= hdr_pos_d;
      rec_left_q <= rec_left_d;
      rec_seen_q <= rec_seen_d;
      rec_type_q <= rec_type_d;
      len_acc_q  <= len_acc_d;
      pay_left_q <= pay_left_d;
      pay_pos_q  <= pay_pos_d;
      keep_q     <= keep_d;
    end
  end

  assign push_o = push;

`ifndef ASSERT_OFF
  a_done_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n == 2'd2 |-> push.r1.kind == tlvx_pkg::KIND_DONE && push.r1.run_last &&
                       !push.r0.run_last)
    else $error("two-word push must end in done");

  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && final_byte_i |=> phase_q == tlvx_pkg::PH_MAGIC && rec_seen_q == '0)
    else $error("parser did not restart after final byte");

  a_pay_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tlvx_pkg::PH_PAYLOAD |-> pay_left_q != '0)
    else $error("payload phase with nothing left");
`endif

endmodule

`default_nettype wire

// ===== rtl/tlvx_result_fifo.sv =====
// ----------------------------------------------------------------------------
// tlvx_result_fifo: result word queue
// Takes zero to two words per cycle, hands out one unless stalled; stalls input when short.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvx_result_fifo #(
  parameter int unsigned Depth = tlvx_pkg::ResultDepthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tlvx_pkg::push_t push_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output tlvx_pkg::result_t    head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] RoomLim = CntW'(Depth - 2);

  tlvx_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr2;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign full_o      = (count_q > RoomLim);
  assign head_o      = mem_q[rd_ptr_q];
  assign wr_ptr2     = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.n == 2'd1) wr_ptr_d = wr_ptr2;
    if (push_i.n == 2'd2) wr_ptr_d = ptr_inc(wr_ptr2);
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      if (push_i.n != 2'd0 && wr_ptr_q == PtrW'(i)) mem_q[i] <= push_i.r0;
      if (push_i.n == 2'd2 && wr_ptr2 == PtrW'(i)) mem_q[i] <= push_i.r1;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue count out of range");

  a_no_ovf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> count_q <= RoomLim)
    else $error("push into queue without room for two words");

  a_pop_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.n == 2'd0 |=> count_q == $past(count_q) - CntW'(1))
    else $error("queue count did not drop on pop");
`endif

endmodule

`default_nettype wire

// ===== rtl/tlv_container_field_extractor.sv =====
// ----------------------------------------------------------------------------
// tlv_container_field_extractor: container record parser, top level
// Magic check, record count, TLV headers, field begin/byte and done words.
// ----------------------------------------------------------------------------
// A result word is written into the result queue as its byte is taken and shows
//   on the output from the queue head. Bytes are taken one per cycle while the
//   queue has room; output drains one word per cycle unless stalled, so a byte
//   yielding two words (field word plus done) leaves as two output words.
// The 4-entry result queue sets the input stall: bytes stall when fewer than
//   two entries are free. Reset (async, active low): parse state idle, queue empty, registers default.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_container_field_extractor #(
  parameter int unsigned MaxFieldBytes = tlvx_pkg::MaxFieldBytesDef,
  parameter int unsigned ResultDepth   = tlvx_pkg::ResultDepthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // config write port
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tlvx_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [tlvx_pkg::CfgDataW-1:0]  cfg_data_i,
  // byte input
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           final_byte_i,
  // result output
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [1:0]                          kind_o,
  output logic [1:0]                          field_id_o,
  output logic [7:0]                          kept_length_o,
  output logic [7:0]                          byte_index_o,
  output logic [7:0]                          byte_value_o,
  output logic                                status_o,
  output logic [31:0]                         rec_total_o,
  output logic                                run_last_o
);

  tlvx_pkg::cfg_t    cfg;
  tlvx_pkg::push_t   push;
  tlvx_pkg::result_t head;
  logic              q_full;
  logic              in_accept;

  // byte taken whenever the queue has room for a worst-case two words
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  tlvx_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // all per-byte work: state update plus result words, in the cycle the byte is taken
  tlvx_parser #(
    .MaxFieldBytes (MaxFieldBytes)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .cfg_i        (cfg),
    .push_o       (push)
  );

  // result queue; decouples input from output stall
  tlvx_result_fifo #(
    .Depth (ResultDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o        = head.kind;
  assign field_id_o    = head.field_id;
  assign kept_length_o = head.kept_length;
  assign byte_index_o  = head.byte_index;
  assign byte_value_o  = head.byte_value;
  assign status_o      = head.status;
  assign rec_total_o   = head.rec_total;
  assign run_last_o    = head.run_last;

endmodule

`default_nettype wire
